// ===== rtl/sau_pkg.sv =====
`default_nettype none

package sau_pkg;

  localparam int WORD_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int SCNT_W  = 7;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 48;

  typedef enum logic [OP_W-1:0] {
    OP_NOP  = 3'd0,
    OP_PUSH = 3'd1,
    OP_SWAP = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4,
    OP_DIV  = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP2,
    S_DIV
  } state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX
  } div_state_t;

endpackage

`default_nettype wire

// ===== rtl/sau_div.sv =====
`default_nettype none

module sau_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [sau_pkg::WORD_W-1:0]  num,
  input  wire logic [sau_pkg::WORD_W-1:0]  den,
  output logic                             done,
  output logic [sau_pkg::WORD_W-1:0]       quot
);
  import sau_pkg::*;

  localparam int IW = $clog2(WORD_W);
  localparam logic [IW-1:0] ITER_LAST = IW'(WORD_W - 1);

  div_state_t        state, state_next;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dmag;
  logic [WORD_W:0]   rem;
  logic              neg;
  logic [IW-1:0]     iter;

  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] diff;
  logic              trial_ok;

  // One restoring step per cycle on the magnitudes.
  assign rem_sh   = {rem[WORD_W-1:0], quo[WORD_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dmag};
  assign trial_ok = !diff[WORD_W+1];

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (iter == ITER_LAST) state_next = DIV_FIX;
      DIV_FIX:  state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    done = 1'b0;
    quot = quo;
    case (state)
      DIV_FIX: begin
        done = 1'b1;
        quot = neg ? (WORD_W'(0) - quo) : quo;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (start) begin
          quo  <= num[WORD_W-1] ? (WORD_W'(0) - num) : num;
          dmag <= den[WORD_W-1] ? (WORD_W'(0) - den) : den;
          rem  <= '0;
          neg  <= num[WORD_W-1] ^ den[WORD_W-1];
          iter <= '0;
        end
      end
      DIV_RUN: begin
        rem  <= trial_ok ? diff[WORD_W:0] : rem_sh;
        quo  <= {quo[WORD_W-2:0], trial_ok};
        iter <= iter + IW'(1);
      end
      default: begin
        iter <= iter;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/stack_arith_unit.sv =====
`default_nettype none

// Sequence: nop, push and every rejected request give their result in the cycle after
// acceptance; add and sub first read the second entry, swap then writes the second entry
// up and the old top down, and div reads the second entry, then the divider retires one
// quotient bit per cycle after setup, the sign is fixed, and the quotient is written back.
// Throughput: one request at a time; the next request is taken once the result is out.
// Reset clears the entry count, the control state and the output valid flag; the stack
// memory itself is not cleared, since no entry is read before a push writes it.
module stack_arith_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // [2:0] opcode, [34:3] push_value, [39:35] zero
  input  wire logic [sau_pkg::IN_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // [1:0] status, [33:2] top_value, [40:34] stack_count, [47:41] zero
  output logic [sau_pkg::OUT_W-1:0]       m_tdata
);
  import sau_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // The whole stack lives in this memory: one write port, one registered read port.
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_data;

  state_t            state, state_next;
  op_t               op_q;
  logic [WORD_W-1:0] opnd_top;
  logic [CW-1:0]     count;
  logic [WORD_W-1:0] top_reg;

  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic              acc;
  op_t               in_op;
  logic [WORD_W-1:0] in_val;
  logic              two_op, under, full, divz, go_exec;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              out_load;
  status_t           out_status;
  logic [CW-1:0]     cnt_new;
  logic [WORD_W-1:0] top_new;
  logic [CW+6:0]     cnt_wide;
  logic [WORD_W-1:0] top_field;

  logic              div_start, div_done;
  logic [WORD_W-1:0] div_quot;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);

  assign acc    = s_tvalid && s_tready;
  assign in_op  = op_t'(s_tdata[2:0]);
  assign in_val = s_tdata[34:3];

  // The top entry is mirrored in top_reg, so checks on it need no memory read.
  assign two_op  = (in_op == OP_SWAP) || (in_op == OP_ADD) ||
                   (in_op == OP_SUB) || (in_op == OP_DIV);
  assign under   = count < CW'(2);
  assign full    = count == CW'(STACK_DEPTH);
  assign divz    = (in_op == OP_DIV) && (top_reg == '0);
  assign go_exec = acc && two_op && !under && !divz;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (go_exec) state_next = S_EXEC;
      S_EXEC: begin
        case (op_q)
          OP_SWAP: state_next = S_SWAP2;
          OP_DIV:  state_next = S_DIV;
          default: state_next = S_IDLE;
        endcase
      end
      S_SWAP2: state_next = S_IDLE;
      S_DIV:   if (div_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs: memory write, register updates and result loading.
  always_comb begin
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cnt_m2[AW-1:0];
    mem_wdata  = rd_data;
    out_load   = 1'b0;
    out_status = ST_OK;
    cnt_new    = count;
    top_new    = top_reg;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        // The output register is free or drains at this edge, so a result fits.
        s_tready = !m_tvalid || m_tready;
        if (acc) begin
          case (in_op)
            OP_PUSH: begin
              out_load = 1'b1;
              if (full) begin
                out_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count[AW-1:0];
                mem_wdata = in_val;
                cnt_new   = count + CW'(1);
                top_new   = in_val;
              end
            end
            OP_SWAP, OP_ADD, OP_SUB, OP_DIV: begin
              if (under) begin
                out_load   = 1'b1;
                out_status = ST_UNDER;
              end else if (divz) begin
                out_load   = 1'b1;
                out_status = ST_DIVZERO;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_EXEC: begin
        // rd_data now holds the second entry.
        case (op_q)
          OP_SWAP: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m1[AW-1:0];
            mem_wdata = rd_data;
          end
          OP_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data + opnd_top;
            cnt_new   = cnt_m1;
            top_new   = rd_data + opnd_top;
            out_load  = 1'b1;
          end
          OP_SUB: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data - opnd_top;
            cnt_new   = cnt_m1;
            top_new   = rd_data - opnd_top;
            out_load  = 1'b1;
          end
          OP_DIV: begin
            div_start = 1'b1;
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      S_SWAP2: begin
        // The second entry was rewritten above the read address, so rd_data still holds it.
        mem_we    = 1'b1;
        mem_wdata = opnd_top;
        top_new   = rd_data;
        out_load  = 1'b1;
      end
      S_DIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wdata = div_quot;
          cnt_new   = cnt_m1;
          top_new   = div_quot;
          out_load  = 1'b1;
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign cnt_wide  = {7'd0, cnt_new};
  assign top_field = (cnt_new == '0) ? '0 : top_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        count    <= cnt_new;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      top_reg <= top_new;
      m_tdata <= {7'd0, cnt_wide[SCNT_W-1:0], top_field, out_status};
    end
    if (go_exec) begin
      op_q     <= in_op;
      opnd_top <= top_reg;
    end
  end

  // Stack memory: the read address always points at the second entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[cnt_m2[AW-1:0]];
  end

  sau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rd_data),
    .den   (opnd_top),
    .done  (div_done),
    .quot  (div_quot)
  );

  // The entry count never passes the stack depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  // A new result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");

  // The divider only ever starts on a nonzero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (opnd_top != '0))
    else $error("divider started with zero divisor");

  // A push onto a stack with room grows it by exactly one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (acc && (in_op == OP_PUSH) && !full) |=> (count == $past(count) + CW'(1)))
    else $error("push did not grow the stack");

  // The divider reports completion only while the sequencer waits on it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

endmodule

`default_nettype wire
